@@ design/sfr_pkg.sv @@
// Shared types and constants for the sensor frame receiver.
`default_nettype none

package sfr_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;

  // Configuration register indexes
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h4B;
  localparam logic [WORD_W-1:0] THRESH_RESET = 16'd2671;

  typedef struct packed {
    logic [WORD_W-1:0] temp_word;
    logic [WORD_W-1:0] humid_word;
    logic [WORD_W-1:0] soil_word;
    logic              checksum_ok;
    logic              fan_on;
  } frame_result_t;

endpackage

`default_nettype wire

@@ design/sensor_frame_receiver.sv @@
// Top level of the sensor frame receiver: byte stream in, frame results out.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  tdata[7:0] rx_byte
//   m_*       out        m_tvalid / m_tready  tdata: words + fan_on, tuser: checksum_ok
//   cfg_*     in         cfg_we               cfg_index selects register, cfg_data value
//
// A received byte is captured in an input register, then decoded by the parser
// when the output slot is free or draining; a frame result lands in the output
// register and m_tvalid rises at the edge where the parser takes its checksum byte.
// One byte is accepted every cycle while the output register is empty or drained.
// A stall on m_tready holds the result and, once the input register is full,
// holds s_tready low. Reset (synchronous) empties both registers, restores the
// register defaults, clears the stored words and turns the fan off.
`default_nettype none

module sensor_frame_receiver (
  input  wire                          clk,
  input  wire                          rst,
  // slave side: tdata = rx_byte[7:0]
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [7:0]                   s_tdata,
  // master side: tdata = temp_word[15:0], humid_word[31:16], soil_word[47:32],
  //              fan_on[48], zero fill [55:49]
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [55:0]                  m_tdata,
  // tuser = checksum_ok[0]
  output logic                         m_tuser,
  // configuration write port
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire  [sfr_pkg::WORD_W-1:0]   cfg_data
);

  logic [sfr_pkg::BYTE_W-1:0] header_byte;
  logic [sfr_pkg::WORD_W-1:0] humid_threshold;

  logic                       in_valid;
  logic [sfr_pkg::BYTE_W-1:0] in_byte;
  logic                       advance;
  logic                       parse_en;

  logic                       done;
  sfr_pkg::frame_result_t     result;
  sfr_pkg::frame_result_t     out_result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte     <= sfr_pkg::HEADER_RESET;
      humid_threshold <= sfr_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfr_pkg::REG_HEADER: header_byte     <= cfg_data[sfr_pkg::BYTE_W-1:0];
        sfr_pkg::REG_THRESH: humid_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // The parser may consume the held byte whenever the output slot is free
  // or is being drained this cycle.
  assign advance  = !m_tvalid || m_tready;
  assign parse_en = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  sfr_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .en              (parse_en),
    .rx_byte         (in_byte),
    .header_byte     (header_byte),
    .humid_threshold (humid_threshold),
    .done            (done),
    .result          (result)
  );

  // Output register: load on a finished frame, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_result <= result;
    end
  end

  assign m_tdata = {7'b0, out_result.fan_on, out_result.soil_word,
                    out_result.humid_word, out_result.temp_word};
  assign m_tuser = out_result.checksum_ok;

endmodule

`default_nettype wire

@@ design/sfr_parser.sv @@
// Frame parser: header hunt, word assembly, checksum and fan decision.
`default_nettype none

module sfr_parser (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire [sfr_pkg::BYTE_W-1:0]    rx_byte,
  input  wire [sfr_pkg::BYTE_W-1:0]    header_byte,
  input  wire [sfr_pkg::WORD_W-1:0]    humid_threshold,
  output logic                         done,
  output sfr_pkg::frame_result_t       result
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_T_HI, PH_T_LO, PH_H_HI, PH_H_LO, PH_S_HI, PH_S_LO, PH_CSUM
  } phase_t;

  phase_t                       phase;
  logic [sfr_pkg::WORD_W-1:0]   temp_store;
  logic [sfr_pkg::WORD_W-1:0]   humid_store;
  logic [sfr_pkg::WORD_W-1:0]   soil_store;
  logic                         fan_state;

  logic [sfr_pkg::BYTE_W-1:0]   sum_lo;
  logic                         sum_ok;
  logic                         fan_next;

  // Only the low bytes reach the low byte of the sum.
  assign sum_lo   = temp_store[7:0] + humid_store[7:0] + soil_store[7:0];
  assign sum_ok   = (sum_lo == rx_byte);
  assign fan_next = sum_ok ? (humid_store > humid_threshold) : fan_state;
  assign done     = en && (phase == PH_CSUM);

  always_comb begin
    result.temp_word   = temp_store;
    result.humid_word  = humid_store;
    result.soil_word   = soil_store;
    result.checksum_ok = sum_ok;
    result.fan_on      = fan_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      temp_store  <= '0;
      humid_store <= '0;
      soil_store  <= '0;
      fan_state   <= 1'b0;
    end else if (en) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == header_byte) begin
            phase <= PH_T_HI;
          end
        end
        PH_T_HI: begin
          temp_store[15:8] <= rx_byte;
          phase            <= PH_T_LO;
        end
        PH_T_LO: begin
          temp_store[7:0] <= rx_byte;
          phase           <= PH_H_HI;
        end
        PH_H_HI: begin
          humid_store[15:8] <= rx_byte;
          phase             <= PH_H_LO;
        end
        PH_H_LO: begin
          humid_store[7:0] <= rx_byte;
          phase            <= PH_S_HI;
        end
        PH_S_HI: begin
          soil_store[15:8] <= rx_byte;
          phase            <= PH_S_LO;
        end
        PH_S_LO: begin
          soil_store[7:0] <= rx_byte;
          phase           <= PH_CSUM;
        end
        PH_CSUM: begin
          fan_state <= fan_next;
          phase     <= PH_HUNT;
        end
        default: phase <= PH_HUNT;
      endcase
    end
  end

endmodule

`default_nettype wire
